// ===== rtl/core/tpd_pkg.sv =====
package tpd_pkg;

  // block sizing
  localparam int MAX_POINTS      = 4096;
  localparam int BASELINE_POINTS = 10;
  localparam int COUNTER_BITS    = 16;

  // fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int THR_W      = 16;
  localparam int SPB_W      = 12;
  localparam int COUNT_W    = 16;
  localparam int STATUS_W   = 2;
  localparam int WRAP_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // derived widths
  localparam int ADDR_W  = $clog2(MAX_POINTS);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int BASE_W  = $clog2(BASELINE_POINTS + 1);
  localparam int IDX_W   = (CNT_W > BASE_W) ? CNT_W : BASE_W;
  localparam int CMP_W   = SAMPLE_W + $clog2(BASELINE_POINTS) + 2;
  localparam int SPB_MAX = (2 ** SPB_W) - 1;
  localparam int POS_MAX = MAX_POINTS - 1 + SPB_MAX * COUNTER_BITS + SPB_MAX / 2;
  localparam int POS_W   = $clog2(POS_MAX + 1);
  localparam int BIT_W   = $clog2(COUNTER_BITS + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPB       = 1'd1;

  localparam logic signed [THR_W-1:0] THR_RESET = -16'sd400;
  localparam logic [SPB_W-1:0]        SPB_RESET = 12'd25;

  // decode status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_EDGE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_PAST_END = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } in_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  trigger_count;
    logic [STATUS_W-1:0] decode_status;
    logic [WRAP_W-1:0]   wrap_count;
    logic                wrapped_now;
  } out_word_t;

  typedef struct packed {
    logic                store;
    logic                start;
    logic                rd_pos;
    logic                base_add;
    logic                scan_begin;
    logic                scan_next;
    logic                edge_take;
    logic                bit_take;
    logic                finish;
    logic [STATUS_W-1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic base_done;
    logic idx_end;
    logic edge_hit;
    logic bits_done;
    logic pos_end;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/core/tpd_ram.sv =====
module tpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/tpd_datapath.sv =====
module tpd_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [tpd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tpd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  tpd_pkg::in_word_t               in_word_i,
  input  tpd_pkg::dp_cmd_t                cmd_i,
  output tpd_pkg::dp_sts_t                sts_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output tpd_pkg::out_word_t              out_word_o
);

  localparam int CMP_W = tpd_pkg::CMP_W;
  localparam int IDX_W = tpd_pkg::IDX_W;
  localparam int POS_W = tpd_pkg::POS_W;
  localparam int CNT_W = tpd_pkg::CNT_W;
  localparam int ADDR_W = tpd_pkg::ADDR_W;
  localparam int CB = tpd_pkg::COUNTER_BITS;

  logic signed [tpd_pkg::THR_W-1:0] thr_q, thr_d;
  logic [tpd_pkg::SPB_W-1:0]        spb_q, spb_d;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;
  logic [CB-1:0]                    prev_q, prev_d;
  logic [tpd_pkg::WRAP_W-1:0]       restart_q, restart_d;
  logic                             seen_q, seen_d;
  logic                             out_valid_q, out_valid_d;

  logic [IDX_W-1:0]                 idx_q, idx_d;
  logic signed [CMP_W-1:0]          sum_q, sum_d;
  logic signed [CMP_W-1:0]          thr10_q, thr10_d;
  logic [POS_W-1:0]                 pos_q, pos_d;
  logic [CB-1:0]                    acc_q, acc_d;
  logic [tpd_pkg::BIT_W-1:0]        bit_q, bit_d;
  tpd_pkg::out_word_t               out_q, out_d;

  logic                             ram_we;
  logic [ADDR_W-1:0]                ram_raddr;
  logic [tpd_pkg::SAMPLE_W-1:0]     rd_data;

  logic signed [CMP_W-1:0]          rd_ext;
  logic signed [CMP_W-1:0]          scaled;
  logic signed [CMP_W-1:0]          diff;
  logic                             in_len;
  logic                             dec_ok;
  logic                             wrapped;

  // sample store
  assign ram_we    = cmd_i.store && (cnt_q < CNT_W'(tpd_pkg::MAX_POINTS));
  assign ram_raddr = cmd_i.rd_pos ? pos_q[ADDR_W-1:0] : idx_q[ADDR_W-1:0];

  tpd_ram #(
    .WIDTH (tpd_pkg::SAMPLE_W),
    .DEPTH (tpd_pkg::MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (in_word_i.sample),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  // comparisons at baseline-count scale
  assign rd_ext = CMP_W'(signed'(rd_data));
  assign scaled = rd_ext * CMP_W'(tpd_pkg::BASELINE_POINTS);
  assign diff   = scaled - sum_q;
  assign in_len = IDX_W'(cnt_q) > idx_q;

  assign sts_o.base_done = idx_q == IDX_W'(tpd_pkg::BASELINE_POINTS);
  assign sts_o.idx_end   = !in_len;
  assign sts_o.edge_hit  = diff <= thr10_q;
  assign sts_o.bits_done = bit_q == tpd_pkg::BIT_W'(CB);
  assign sts_o.pos_end   = pos_q >= POS_W'(cnt_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign dec_ok  = cmd_i.status == tpd_pkg::STATUS_OK;
  assign wrapped = dec_ok && seen_q && (prev_q > acc_q);

  always_comb begin
    thr_d       = thr_q;
    spb_d       = spb_q;
    cnt_d       = cnt_q;
    prev_d      = prev_q;
    restart_d   = restart_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    thr10_d     = thr10_q;
    pos_d       = pos_q;
    acc_d       = acc_q;
    bit_d       = bit_q;
    out_d       = out_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        tpd_pkg::CFG_THRESHOLD: thr_d = signed'(cfg_data_i);
        tpd_pkg::CFG_SPB:       spb_d = cfg_data_i[tpd_pkg::SPB_W-1:0];
        default: ;
      endcase
    end

    if (ram_we) begin
      cnt_d = cnt_q + CNT_W'(1);
    end

    if (cmd_i.start) begin
      idx_d   = '0;
      sum_d   = '0;
      thr10_d = CMP_W'(thr_q) * CMP_W'(tpd_pkg::BASELINE_POINTS);
    end

    if (cmd_i.base_add) begin
      sum_d = in_len ? sum_q + rd_ext : sum_q;
      idx_d = idx_q + IDX_W'(1);
    end

    if (cmd_i.scan_begin) begin
      idx_d = '0;
    end

    if (cmd_i.scan_next) begin
      idx_d = idx_q + IDX_W'(1);
    end

    // first bit centre lies one and a half periods past the edge
    if (cmd_i.edge_take) begin
      pos_d = POS_W'(idx_q) + POS_W'(spb_q) + POS_W'(spb_q >> 1);
      acc_d = '0;
      bit_d = '0;
    end

    if (cmd_i.bit_take) begin
      acc_d = (acc_q << 1) | CB'(diff < thr10_q);
      pos_d = pos_q + POS_W'(spb_q);
      bit_d = bit_q + tpd_pkg::BIT_W'(1);
    end

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.finish) begin
      cnt_d     = '0;
      restart_d = restart_q + tpd_pkg::WRAP_W'(wrapped);
      if (dec_ok) begin
        seen_d = 1'b1;
        prev_d = acc_q;
      end
      out_valid_d         = 1'b1;
      out_d.trigger_count = dec_ok ? tpd_pkg::COUNT_W'(acc_q) : '0;
      out_d.decode_status = cmd_i.status;
      out_d.wrap_count    = restart_d;
      out_d.wrapped_now   = wrapped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= tpd_pkg::THR_RESET;
      spb_q       <= tpd_pkg::SPB_RESET;
      cnt_q       <= '0;
      prev_q      <= '0;
      restart_q   <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      thr_q       <= thr_d;
      spb_q       <= spb_d;
      cnt_q       <= cnt_d;
      prev_q      <= prev_d;
      restart_q   <= restart_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    sum_q   <= sum_d;
    thr10_q <= thr10_d;
    pos_q   <= pos_d;
    acc_q   <= acc_d;
    bit_q   <= bit_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== rtl/core/tpd_ctrl.sv =====
module tpd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  tpd_pkg::dp_sts_t sts_i,
  output tpd_pkg::dp_cmd_t cmd_o
);

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_BRD  = 4'd2;
  localparam logic [3:0] S_BACC = 4'd3;
  localparam logic [3:0] S_SRD  = 4'd4;
  localparam logic [3:0] S_SEV  = 4'd5;
  localparam logic [3:0] S_PRD  = 4'd6;
  localparam logic [3:0] S_PEV  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]                   state_q, state_d;
  logic [tpd_pkg::STATUS_W-1:0] stat_q, stat_d;

  assign in_ready_o = state_q == S_LOAD;

  always_comb begin
    state_d      = state_q;
    stat_d       = stat_q;
    cmd_o        = '0;
    cmd_o.status = stat_q;
    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.store = 1'b1;
          if (in_last_i) begin
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd_o.start = 1'b1;
        state_d     = S_BRD;
      end
      S_BRD: begin
        if (sts_i.base_done) begin
          cmd_o.scan_begin = 1'b1;
          state_d          = S_SRD;
        end else begin
          state_d = S_BACC;
        end
      end
      S_BACC: begin
        cmd_o.base_add = 1'b1;
        state_d        = S_BRD;
      end
      S_SRD: begin
        if (sts_i.idx_end) begin
          stat_d  = tpd_pkg::STATUS_NO_EDGE;
          state_d = S_FIN;
        end else begin
          state_d = S_SEV;
        end
      end
      S_SEV: begin
        if (sts_i.edge_hit) begin
          cmd_o.edge_take = 1'b1;
          state_d         = S_PRD;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = S_SRD;
        end
      end
      S_PRD: begin
        if (sts_i.bits_done) begin
          stat_d  = tpd_pkg::STATUS_OK;
          state_d = S_FIN;
        end else if (sts_i.pos_end) begin
          stat_d  = tpd_pkg::STATUS_PAST_END;
          state_d = S_FIN;
        end else begin
          cmd_o.rd_pos = 1'b1;
          state_d      = S_PEV;
        end
      end
      S_PEV: begin
        cmd_o.bit_take = 1'b1;
        state_d        = S_PRD;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      stat_q  <= tpd_pkg::STATUS_OK;
    end else begin
      state_q <= state_d;
      stat_q  <= stat_d;
    end
  end

endmodule

// ===== rtl/core/trigger_pattern_decoder.sv =====
// channel   | handshake                      | word
// ----------+--------------------------------+---------------------------------------
// in        | in_valid_i / in_ready_o        | in_word_i: sample, last_sample
// out       | out_valid_o / out_ready_i      | out_word_o: count, status, wraps, wrap
// cfg       | cfg_valid_i / cfg_ready_o      | cfg_index_i, cfg_data_i
//
// one input word is taken per cycle while a waveform is loading
// after the last word the decode runs on the single read port of the sample store,
// each read in a read state and an evaluate state: baseline sum, edge scan, then
// the bit reads; with no edge found the scan runs to the end of the stored waveform
// input is not taken during the decode; a result waits in the output register
// and holds back only the end of the next decode, reset clears all control state

module trigger_pattern_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tpd_pkg::in_word_t              in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tpd_pkg::out_word_t             out_word_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tpd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tpd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  tpd_pkg::dp_cmd_t cmd;
  tpd_pkg::dp_sts_t sts;

  // registers can always be written
  assign cfg_ready_o = 1'b1;

  // sequencing: load, baseline sum, edge scan, bit reads, result
  tpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_word_i.last_sample),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // sample store, arithmetic, wrap tracking and output register
  tpd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== dv/trigger_pattern_decoder_tb.sv =====
`timescale 1ns / 100ps

module trigger_pattern_decoder_tb;
  import tpd_pkg::*;

  // run shaping
  localparam int N_ITEMS     = 1100;
  localparam int QUIET_TAIL  = 250;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_GAP  = 8;
  localparam int DRAIN_GAP   = 100;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_word_t              in_word_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_word_t             out_word_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  trigger_pattern_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // shadow copy of the decoder state and its registers
  logic signed [SAMPLE_W-1:0] wave_mem [MAX_POINTS];
  int unsigned                wave_len  = 0;
  logic signed [THR_W-1:0]    thr_reg   = THR_RESET;
  logic [SPB_W-1:0]           spb_reg   = SPB_RESET;
  logic [COUNT_W-1:0]         last_code = '0;
  logic [WRAP_W-1:0]          restarts  = '0;
  logic                       seen_ok   = 1'b0;

  // words waiting to be sent, and decode reports still owed by the block
  in_word_t    sample_q [$];
  out_word_t   report_q [$];

  int unsigned sent_cnt  = 0;
  int unsigned in_count  = 0;
  int unsigned err_cnt   = 0;
  int unsigned tx_gap    = 0;
  int unsigned rx_gap    = 0;
  int unsigned hold_left = 0;
  bit          in_acc    = 1'b0;
  bit          cfg_acc   = 1'b0;
  bit          quiet     = 1'b0;
  bit          hold_arm  = 1'b0;
  bit          hold_done = 1'b0;

  initial begin : clock_gen
    forever #4 clk_i = ~clk_i;
  end

  // store one accepted sample; on the last mark decode the waveform and queue the report
  function automatic void absorb_sample(input in_word_t w);
    longint      base_sum;
    longint      lim;
    longint      start_pos;
    longint      pos;
    longint      sp;
    int          edge_at;
    logic [15:0] code;
    logic [1:0]  status;
    out_word_t   rep;
    if (wave_len < MAX_POINTS) begin
      wave_mem[wave_len] = w.sample;
      wave_len++;
    end
    if (!w.last_sample) return;

    // baseline kept as a plain sum, short waveforms pad with zero
    base_sum = 0;
    for (int i = 0; i < BASELINE_POINTS; i++) begin
      if (i < wave_len) base_sum += wave_mem[i];
    end
    lim = BASELINE_POINTS * longint'(thr_reg);
    sp  = longint'(spb_reg);

    // start edge is the first sample at or below the threshold
    edge_at = -1;
    for (int i = 0; i < wave_len; i++) begin
      if (BASELINE_POINTS * longint'(wave_mem[i]) - base_sum <= lim) begin
        edge_at = i;
        break;
      end
    end

    code = '0;
    if (edge_at < 0) begin
      status = STATUS_NO_EDGE;
    end else begin
      status    = STATUS_OK;
      start_pos = edge_at + sp + sp / 2;
      // bits msb first, one period apart, strictly below counts as one
      for (int b = 0; b < COUNTER_BITS; b++) begin
        pos = start_pos + b * sp;
        if (pos >= wave_len) begin
          status = STATUS_PAST_END;
          break;
        end
        code = {code[14:0], (BASELINE_POINTS * longint'(wave_mem[pos]) - base_sum < lim)};
      end
      if (status != STATUS_OK) code = '0;
    end

    rep.wrapped_now = 1'b0;
    if (status == STATUS_OK) begin
      // first good decode only seeds the previous value
      if (!seen_ok) begin
        seen_ok = 1'b1;
      end else if (last_code > code) begin
        restarts        = restarts + 1'b1;
        rep.wrapped_now = 1'b1;
      end
      last_code = code;
    end
    rep.trigger_count = code;
    rep.decode_status = status;
    rep.wrap_count    = restarts;
    report_q = {report_q, rep};
    wave_len = 0;
  endfunction

  task automatic flag_field(input string field, input logic [15:0] want_v,
                            input logic [15:0] got_v);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch on %s: expected %h, got %h", field, want_v, got_v);
  endtask

  // sample everything at the rising edge, before the block's own updates land
  always @(posedge clk_i) begin : monitor
    out_word_t want;
    if (!rst_ni) begin
      in_acc  = 1'b0;
      cfg_acc = 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (report_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("report word with none pending: %h", out_word_o);
        end else begin
          want = report_q.pop_front();
          if (out_word_o.trigger_count !== want.trigger_count)
            flag_field("trigger_count", want.trigger_count, out_word_o.trigger_count);
          if (out_word_o.decode_status !== want.decode_status)
            flag_field("decode_status", want.decode_status, out_word_o.decode_status);
          if (out_word_o.wrap_count !== want.wrap_count)
            flag_field("wrap_count", want.wrap_count, out_word_o.wrap_count);
          if (out_word_o.wrapped_now !== want.wrapped_now)
            flag_field("wrapped_now", want.wrapped_now, out_word_o.wrapped_now);
        end
      end
      cfg_acc = cfg_valid_i && cfg_ready_o;
      if (cfg_acc) begin
        if (cfg_index_i == CFG_THRESHOLD) thr_reg = cfg_data_i;
        else if (cfg_index_i == CFG_SPB) spb_reg = cfg_data_i[SPB_W-1:0];
      end
      in_acc = in_valid_i && in_ready_o;
      if (in_acc) begin
        absorb_sample(in_word_i);
        in_count++;
      end
    end
  end

  // sample sender: valid holds until taken, random idle bursts
  always @(negedge clk_i) begin : sample_driver
    if (!in_valid_i || in_acc) begin
      if (tx_gap != 0) begin
        tx_gap     <= tx_gap - 1;
        in_valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(5) == 0) begin
        tx_gap     <= $urandom_range(2, 0);
        in_valid_i <= 1'b0;
      end else if (sample_q.size() != 0) begin
        in_word_i  <= sample_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // one long receiver hold-off, started while a report waits, so input backs up
  always @(negedge clk_i) begin : hold_timer
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done && out_valid_o) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // report receiver with its own random stall bursts
  always @(negedge clk_i) begin : report_sink
    if (rx_gap != 0) begin
      rx_gap      <= rx_gap - 1;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(5) == 0) begin
      rx_gap      <= $urandom_range(2, 0);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= (hold_left == 0);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_acc);
    cfg_valid_i <= 1'b0;
  endtask

  // block is idle once every sent word is taken and every report has come back
  task automatic wait_quiet;
    do @(negedge clk_i); while (in_count != sent_cnt || report_q.size() != 0);
    repeat (SETTLE_GAP) @(negedge clk_i);
  endtask

  task automatic push_sample(input int v, input bit last);
    in_word_t w;
    w.sample      = v[15:0];
    w.last_sample = last;
    sample_q = {sample_q, w};
    sent_cnt++;
  endtask

  // pulse-coded waveform: baseline, start pulse, then sixteen bit cells msb first
  task automatic push_coded(input int base, input int lvl_thr, input int spb,
                            input logic [15:0] code, input int lead, input int tail,
                            input int noise, input int cut);
    int eff;
    int start;
    int total;
    int r;
    int v;
    eff   = (spb < 1) ? 1 : spb;
    start = BASELINE_POINTS + lead;
    total = start + eff * (COUNTER_BITS + 1) + tail;
    if (cut > 0 && cut < total) total = cut;
    for (int j = 0; j < total; j++) begin
      r = (j < start) ? -1 : (j - start) / eff;
      v = base + int'($urandom_range(2 * noise, 0)) - noise;
      // low level well below the threshold for the start pulse and for one bits
      if (r == 0 || (r >= 1 && r <= COUNTER_BITS && code[COUNTER_BITS - r])) v += 2 * lvl_thr;
      push_sample(v, j == total - 1);
    end
  endtask

  initial begin : stimulus
    int thr_v;
    int spb_v;
    int pick;
    int lvl;
    int len;
    int n_waves;
    bit thr_first;
    int unsigned rand_sent0;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, one-word waveforms: no edge, past end, no edge
    @(posedge clk_i);
    push_sample(0, 1'b1);
    push_sample(-32768, 1'b1);
    push_sample(32767, 1'b1);
    wait_quiet();

    // one sample per bit, first good decode, no restart, restart, failed decode
    write_reg(CFG_THRESHOLD, -16'sd400);
    write_reg(CFG_SPB, 16'd1);
    @(posedge clk_i);
    push_coded(0, -400, 1, 16'h8001, 0, 2, 20, 0);
    push_coded(0, -400, 1, 16'hFFFF, 3, 0, 20, 0);
    push_coded(0, -400, 1, 16'h0000, 1, 1, 20, 0);
    for (int j = 0; j < 12; j++) push_sample(0, j == 11);
    push_coded(500, -400, 1, 16'h1234, 0, 0, 20, 0);
    // edge exactly on the threshold, bits alternating just below and exactly on it
    for (int j = 0; j < BASELINE_POINTS; j++) push_sample(0, 1'b0);
    push_sample(-400, 1'b0);
    for (int k = 0; k < COUNTER_BITS; k++) push_sample((k % 2 == 0) ? -401 : -400, k == 15);
    wait_quiet();

    // zero bit period: every bit read at the edge, short waveform with zero padding
    write_reg(CFG_SPB, 16'd0);
    @(posedge clk_i);
    for (int j = 0; j < 4; j++) push_sample(1000, 1'b0);
    push_sample(-3000, 1'b1);
    for (int j = 0; j < BASELINE_POINTS; j++) push_sample(0, 1'b0);
    push_sample(-400, 1'b1);
    wait_quiet();

    // most negative threshold against full-scale samples
    write_reg(CFG_THRESHOLD, 16'h8000);
    write_reg(CFG_SPB, 16'd1);
    @(posedge clk_i);
    for (int j = 0; j < BASELINE_POINTS; j++) push_sample(32767, 1'b0);
    push_sample(-32768, 1'b0);
    for (int k = 0; k < COUNTER_BITS; k++) push_sample((k % 2 == 0) ? -32768 : 32767, k == 15);
    wait_quiet();

    // most positive threshold, longest bit period with spare data bits set
    write_reg(CFG_THRESHOLD, 16'h7FFF);
    write_reg(CFG_SPB, 16'hFFFF);
    @(posedge clk_i);
    for (int j = 0; j < 5; j++) push_sample(int'($urandom), j == 4);
    wait_quiet();

    // store overflow: words past the depth are dropped, the last mark still ends it
    write_reg(CFG_THRESHOLD, -16'sd400);
    write_reg(CFG_SPB, 16'd1);
    @(posedge clk_i);
    push_coded(-200, -400, 1, 16'hC3A5, 0, MAX_POINTS + 4 - 27, 20, 0);
    wait_quiet();

    // random phases, each with its own settings and a batch of waveforms
    rand_sent0 = sent_cnt;
    while (sent_cnt - rand_sent0 < N_ITEMS) begin
      pick = $urandom_range(19);
      if (pick < 17) thr_v = -int'($urandom_range(3000, 100));
      else thr_v = int'($urandom_range(65535, 0)) - 32768;
      pick = $urandom_range(19);
      if (pick < 13) spb_v = $urandom_range(4, 1);
      else if (pick < 17) spb_v = $urandom_range(30, 5);
      else if (pick == 17) spb_v = 0;
      else if (pick == 18) spb_v = SPB_MAX;
      else spb_v = $urandom_range(SPB_MAX, 31);

      thr_first = $urandom_range(1);
      for (int k = 0; k < 2; k++) begin
        if ((k == 0) == thr_first) write_reg(CFG_THRESHOLD, thr_v[15:0]);
        else write_reg(CFG_SPB, {4'($urandom), spb_v[11:0]});
      end

      @(posedge clk_i);
      hold_arm = 1'b1;
      // no idling on either side towards the end
      if (sent_cnt - rand_sent0 + QUIET_TAIL >= N_ITEMS) quiet = 1'b1;
      lvl     = (thr_v < -100) ? thr_v : -400;
      n_waves = $urandom_range(8, 3);
      repeat (n_waves) begin
        pick = $urandom_range(9);
        if (pick == 0) begin
          // pure noise, any value, 1 to 40 samples long
          len = $urandom_range(40, 1);
          for (int j = 0; j < len; j++) push_sample(int'($urandom), j == len - 1);
        end else begin
          // mostly well formed, some cut short, long bit periods always cut
          push_coded(int'($urandom_range(16000, 0)) - 8000, lvl, spb_v, 16'($urandom),
                     $urandom_range(8, 0), $urandom_range(5, 0), -lvl / 8,
                     (pick == 1 || spb_v > 40) ? int'($urandom_range(60, 1)) : 0);
        end
      end
      wait_quiet();
    end

    repeat (DRAIN_GAP) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
